/* hw/rtl/rfc_pkg.sv */
package rfc_pkg;

    localparam int TREES_DEF    = 16;
    localparam int CLASSES_DEF  = 8;
    localparam int NODES_DEF    = 256;
    localparam int FEATURES_DEF = 64;

    localparam int OP_W    = 3;
    localparam int TREE_W  = 4;
    localparam int NODE_W  = 8;
    localparam int FIDX_W  = 7;
    localparam int NUM_W   = 16;
    localparam int CLS_W   = 3;
    localparam int CNT_W   = 16;
    localparam int LABEL_W = 8;
    localparam int SCORE_W = 21;
    localparam int FAULT_W = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // quotient bits of count * 2^16 / total with count <= total
    localparam int QBITS = 17;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_WR_NODE  = 3'd0,
        OP_WR_LEAF  = 3'd1,
        OP_WR_LABEL = 3'd2,
        OP_WR_FEAT  = 3'd3,
        OP_CLASSIFY = 3'd4
    } t_op;

    localparam logic [CFG_IDX_W-1:0] CFG_TREES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLASSES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH   = 2'd2;

    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_DEPTH = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_EMPTY = 2'd2;

    typedef struct packed {
        logic signed [FIDX_W-1:0] feat;
        logic signed [NUM_W-1:0]  thresh;
        logic [NODE_W-1:0]        left;
        logic [NODE_W-1:0]        right;
    } t_node;

endpackage

/* hw/rtl/random_forest_classifier_unit.sv */
// Writes go straight into the memories; a classify walks each tree to a leaf, checks its counts,
// sums the leaf counts, divides each class count by the total and adds it to the score, then votes.
// Throughput: one write word per cycle; classify is sequential, input stalled meanwhile.
// The shared unit is a 17-step restoring divider; memories have one read port each.
// Reset (sync, active low) clears control and config to 16 trees, 8 classes, depth 255.
module random_forest_classifier_unit #(
    parameter int TREES    = rfc_pkg::TREES_DEF,
    parameter int CLASSES  = rfc_pkg::CLASSES_DEF,
    parameter int NODES    = rfc_pkg::NODES_DEF,
    parameter int FEATURES = rfc_pkg::FEATURES_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [rfc_pkg::OP_W-1:0]          i_op,
    input  logic [rfc_pkg::TREE_W-1:0]        i_tree,
    input  logic [rfc_pkg::NODE_W-1:0]        i_node,
    input  logic signed [rfc_pkg::FIDX_W-1:0] i_feature_index,
    input  logic signed [rfc_pkg::NUM_W-1:0]  i_number,
    input  logic [rfc_pkg::NODE_W-1:0]        i_left_child,
    input  logic [rfc_pkg::NODE_W-1:0]        i_right_child,
    input  logic [rfc_pkg::CLS_W-1:0]         i_class_index,
    input  logic [rfc_pkg::CNT_W-1:0]         i_sample_count,
    input  logic [rfc_pkg::LABEL_W-1:0]       i_label,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [rfc_pkg::LABEL_W-1:0]       o_predicted_label,
    output logic [rfc_pkg::CLS_W-1:0]         o_winning_class,
    output logic [rfc_pkg::SCORE_W-1:0]       o_best_score,
    output logic [rfc_pkg::FAULT_W-1:0]       o_fault,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rfc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import rfc_pkg::*;

    localparam int AW   = $clog2(TREES * NODES);
    localparam int LAW  = $clog2(TREES * NODES * CLASSES);
    localparam int FW   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
    localparam int CIW  = $clog2(CLASSES);
    localparam int CCW  = $clog2(CLASSES + 1);
    localparam int TCW  = $clog2(TREES + 1);
    localparam int SUMW = CNT_W + $clog2(CLASSES);
    localparam int QCW  = $clog2(QBITS);

    typedef enum logic [14:0] {
        S_IDLE  = 15'h0001,
        S_NWAIT = 15'h0002,
        S_NODE  = 15'h0004,
        S_FWAIT = 15'h0008,
        S_CMP   = 15'h0010,
        S_LWAIT = 15'h0020,
        S_LACC  = 15'h0040,
        S_LCHK  = 15'h0080,
        S_DWAIT = 15'h0100,
        S_DINIT = 15'h0200,
        S_DIV   = 15'h0400,
        S_DADD  = 15'h0800,
        S_NEXT  = 15'h1000,
        S_VOTE  = 15'h2000,
        S_DONE  = 15'h4000
    } t_state;

    t_state r_state, n_state;

    logic [4:0] r_trees;
    logic [3:0] r_classes;
    logic [7:0] r_depth;

    // memories
    t_node              node_mem [TREES*NODES];
    logic [CNT_W-1:0]   leaf_mem [TREES*NODES*CLASSES];
    logic [NUM_W-1:0]   feat_mem [FEATURES];
    logic [LABEL_W-1:0] r_labels [CLASSES];

    t_node              r_nword;
    logic [CNT_W-1:0]   r_lword;
    logic [NUM_W-1:0]   r_fword;

    logic [AW-1:0]      r_naddr, r_base;
    logic [LAW-1:0]     r_laddr, r_lbase;
    logic [FW-1:0]      r_faddr;
    logic               r_fok;
    logic [TCW-1:0]     r_t;
    logic [CCW-1:0]     r_c;
    logic [7:0]         r_steps;
    logic [SUMW-1:0]    r_total;
    logic [SUMW:0]      r_rem;
    logic [QBITS-1:0]   r_q;
    logic [QCW-1:0]     r_qcnt;
    logic [SCORE_W-1:0] r_score [CLASSES];
    logic [SCORE_W-1:0] r_best;
    logic [CIW-1:0]     r_win;
    logic [FAULT_W-1:0] r_fault;

    logic               r_ovalid;
    logic [LABEL_W-1:0] r_olabel;
    logic [CLS_W-1:0]   r_owin;
    logic [SCORE_W-1:0] r_oscore;
    logic [FAULT_W-1:0] r_ofault;

    logic               in_acc;
    logic [TCW-1:0]     ntrees;
    logic [CCW-1:0]     ncls;
    logic               cls_last;
    logic signed [NUM_W-1:0] x_val;
    logic [NODE_W-1:0]  next_node;
    logic [SCORE_W:0]   score_sum;
    logic [SUMW:0]      rem_sub;
    logic               rem_ge;
    logic               out_free;

    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign ntrees = (32'(r_trees) > TREES) ? TCW'(TREES) : TCW'(r_trees);
    always_comb begin
        if (r_classes == 4'd0) begin
            ncls = CCW'(1);
        end else if (32'(r_classes) > CLASSES) begin
            ncls = CCW'(CLASSES);
        end else begin
            ncls = CCW'(r_classes);
        end
    end
    assign cls_last = (r_c == ncls - CCW'(1));

    assign x_val     = r_fok ? $signed(r_fword) : '0;
    assign next_node = (x_val <= r_nword.thresh) ? r_nword.left : r_nword.right;
    assign score_sum = {1'b0, r_score[r_c[CIW-1:0]]} + (SCORE_W+1)'(r_q);
    assign rem_ge    = (r_rem >= {1'b0, r_total});
    assign rem_sub   = r_rem - {1'b0, r_total};
    assign out_free  = !r_ovalid || !i_out_stall;

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trees   <= 5'd16;
            r_classes <= 4'd8;
            r_depth   <= 8'd255;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_TREES:   r_trees   <= i_cfg_data[4:0];
                CFG_CLASSES: r_classes <= i_cfg_data[3:0];
                CFG_DEPTH:   r_depth   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // store writes and registered reads
    always_ff @(posedge i_clk) begin
        if (in_acc && i_op == OP_WR_NODE && 32'(i_tree) < TREES && 32'(i_node) < NODES) begin
            node_mem[AW'(32'(i_tree) * NODES + 32'(i_node))] <=
                '{feat: i_feature_index, thresh: i_number,
                  left: i_left_child, right: i_right_child};
        end
        if (in_acc && i_op == OP_WR_LEAF && 32'(i_tree) < TREES && 32'(i_node) < NODES
                && 32'(i_class_index) < CLASSES) begin
            leaf_mem[LAW'((32'(i_tree) * NODES + 32'(i_node)) * CLASSES
                          + 32'(i_class_index))] <= i_sample_count;
        end
        if (in_acc && i_op == OP_WR_FEAT && !i_feature_index[FIDX_W-1]
                && 32'(i_feature_index) < FEATURES) begin
            feat_mem[FW'(i_feature_index)] <= i_number;
        end
        if (in_acc && i_op == OP_WR_LABEL && 32'(i_class_index) < CLASSES) begin
            r_labels[CIW'(i_class_index)] <= i_label;
        end
        r_nword <= node_mem[r_naddr];
        r_lword <= leaf_mem[r_laddr];
        r_fword <= feat_mem[r_faddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc && i_op == OP_CLASSIFY) begin
                n_state = (ntrees == '0) ? S_VOTE : S_NWAIT;
            end
            S_NWAIT: n_state = S_NODE;
            S_NODE: begin
                if (r_nword.feat[FIDX_W-1]) begin
                    n_state = S_LWAIT;
                end else if (r_steps >= r_depth) begin
                    n_state = S_NEXT;
                end else begin
                    n_state = S_FWAIT;
                end
            end
            S_FWAIT: n_state = S_CMP;
            S_CMP:   n_state = (32'(next_node) >= NODES) ? S_NEXT : S_NWAIT;
            S_LWAIT: n_state = S_LACC;
            S_LACC:  n_state = cls_last ? S_LCHK : S_LWAIT;
            S_LCHK:  n_state = (r_total == '0) ? S_NEXT : S_DWAIT;
            S_DWAIT: n_state = S_DINIT;
            S_DINIT: n_state = S_DIV;
            S_DIV:   n_state = (r_qcnt == QCW'(QBITS - 1)) ? S_DADD : S_DIV;
            S_DADD:  n_state = cls_last ? S_NEXT : S_DWAIT;
            S_NEXT:  n_state = (r_t == ntrees - TCW'(1)) ? S_VOTE : S_NWAIT;
            S_VOTE:  n_state = cls_last ? S_DONE : S_VOTE;
            S_DONE:  n_state = out_free ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath sequencing
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_naddr <= '0;
                r_base  <= '0;
                r_t     <= '0;
                r_c     <= '0;
                r_steps <= '0;
                r_fault <= FAULT_NONE;
                r_best  <= '0;
                r_win   <= '0;
                for (int i = 0; i < CLASSES; i++) begin
                    r_score[i] <= '0;
                end
            end
            S_NODE: begin
                r_faddr <= FW'(r_nword.feat);
                r_fok   <= (32'(r_nword.feat) < FEATURES);
                r_lbase <= LAW'(32'(r_naddr) * CLASSES);
                r_laddr <= LAW'(32'(r_naddr) * CLASSES);
                r_c     <= '0;
                r_total <= '0;
                if (!r_nword.feat[FIDX_W-1] && r_steps >= r_depth
                        && r_fault == FAULT_NONE) begin
                    r_fault <= FAULT_DEPTH;
                end
            end
            S_CMP: begin
                r_naddr <= r_base + AW'(next_node);
                r_steps <= r_steps + 8'd1;
                if (32'(next_node) >= NODES && r_fault == FAULT_NONE) begin
                    r_fault <= FAULT_DEPTH;
                end
            end
            S_LACC: begin
                r_total <= r_total + SUMW'(r_lword);
                r_laddr <= r_laddr + LAW'(1);
                r_c     <= r_c + CCW'(1);
            end
            S_LCHK: begin
                r_c     <= '0;
                r_laddr <= r_lbase;
                if (r_total == '0 && r_fault == FAULT_NONE) begin
                    r_fault <= FAULT_EMPTY;
                end
            end
            S_DINIT: begin
                r_rem  <= (SUMW+1)'(r_lword);
                r_q    <= '0;
                r_qcnt <= '0;
            end
            S_DIV: begin
                // one restoring step per cycle, quotient MSB first
                r_rem  <= rem_ge ? {rem_sub[SUMW-1:0], 1'b0} : {r_rem[SUMW-1:0], 1'b0};
                r_q    <= {r_q[QBITS-2:0], rem_ge};
                r_qcnt <= r_qcnt + QCW'(1);
            end
            S_DADD: begin
                r_score[r_c[CIW-1:0]] <= score_sum[SCORE_W] ? SCORE_MAX
                                                            : score_sum[SCORE_W-1:0];
                r_c     <= r_c + CCW'(1);
                r_laddr <= r_laddr + LAW'(1);
            end
            S_NEXT: begin
                r_t     <= r_t + TCW'(1);
                r_base  <= r_base + AW'(NODES);
                r_naddr <= r_base + AW'(NODES);
                r_steps <= '0;
                r_c     <= '0;
            end
            S_VOTE: begin
                if (r_score[r_c[CIW-1:0]] >= r_best) begin
                    r_best <= r_score[r_c[CIW-1:0]];
                    r_win  <= r_c[CIW-1:0];
                end
                r_c <= r_c + CCW'(1);
            end
            S_DONE: begin
                if (out_free) begin
                    r_olabel <= r_labels[r_win];
                    r_owin   <= CLS_W'(r_win);
                    r_oscore <= r_best;
                    r_ofault <= r_fault;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid       = r_ovalid;
    assign o_predicted_label = r_olabel;
    assign o_winning_class   = r_owin;
    assign o_best_score      = r_oscore;
    assign o_fault           = r_ofault;

    a_busy_after_classify: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_op == OP_CLASSIFY) |=> o_in_stall)
        else $error("classify did not stall input");

    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DADD) |-> (r_q <= QBITS'(65536)))
        else $error("leaf probability above one");

    a_fault_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_fault != 2'd3))
        else $error("bad fault code");

    a_walk_tree_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE) |-> (r_t < ntrees))
        else $error("walk past last tree");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import rfc_pkg::*;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic [TREE_W-1:0]        tree;
        logic [NODE_W-1:0]        node;
        logic signed [FIDX_W-1:0] fidx;
        logic signed [NUM_W-1:0]  num;
        logic [NODE_W-1:0]        lc;
        logic [NODE_W-1:0]        rc;
        logic [CLS_W-1:0]         cls;
        logic [CNT_W-1:0]         cnt;
        logic [LABEL_W-1:0]       lab;
    } word_t;

    typedef struct {
        logic [LABEL_W-1:0] lab;
        logic [CLS_W-1:0]   win;
        logic [SCORE_W-1:0] score;
        logic [FAULT_W-1:0] fault;
    } vote_t;

    localparam int NT = TREES_DEF;
    localparam int NN = NODES_DEF;
    localparam int NC = CLASSES_DEF;
    localparam int NF = FEATURES_DEF;
    // split nodes only ever test these feature slots
    localparam int NF_USED = 8;
    localparam int CYCLE_LIMIT = 40000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_stall = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    word_t cur = '{default: '0};

    logic o_in_stall, o_out_valid, o_cfg_ready;
    logic [LABEL_W-1:0] o_predicted_label;
    logic [CLS_W-1:0]   o_winning_class;
    logic [SCORE_W-1:0] o_best_score;
    logic [FAULT_W-1:0] o_fault;

    random_forest_classifier_unit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(o_in_stall),
        .i_op(cur.op), .i_tree(cur.tree), .i_node(cur.node),
        .i_feature_index(cur.fidx), .i_number(cur.num),
        .i_left_child(cur.lc), .i_right_child(cur.rc),
        .i_class_index(cur.cls), .i_sample_count(cur.cnt), .i_label(cur.lab),
        .o_out_valid(o_out_valid), .i_out_stall(out_stall),
        .o_predicted_label(o_predicted_label), .o_winning_class(o_winning_class),
        .o_best_score(o_best_score), .o_fault(o_fault),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    // forest image as the block should hold it
    logic signed [FIDX_W-1:0] split_of [NT*NN];
    logic signed [NUM_W-1:0]  thr_of   [NT*NN];
    logic [NODE_W-1:0]        left_of  [NT*NN];
    logic [NODE_W-1:0]        right_of [NT*NN];
    logic [CNT_W-1:0]         count_of [NT*NN*NC];
    logic [LABEL_W-1:0]       label_of [NC];
    logic signed [NUM_W-1:0]  feat_of  [NF];
    logic [4:0] trees_cfg = 5'd16;
    logic [3:0] classes_cfg = 4'd8;
    logic [7:0] depth_cfg = 8'd255;

    word_t word_queue[$];
    vote_t vote_queue[$];
    bit in_taken = 0;
    int send_idle_pct = 16;
    int recv_stall_pct = 57;
    int errors = 0;
    int words_sent = 0;
    int votes_seen = 0;
    int faults_seen = 0;
    int cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic vote_t forest_vote();
        vote_t v;
        int nt, nc, n, steps, base;
        logic [FAULT_W-1:0] tf, first;
        logic signed [NUM_W-1:0] x;
        longint total, p, s;
        logic [SCORE_W-1:0] score [NC];
        bit stop;
        nt = (trees_cfg > NT) ? NT : trees_cfg;
        nc = (classes_cfg < 1) ? 1 : ((classes_cfg > NC) ? NC : classes_cfg);
        for (int c = 0; c < NC; c++) score[c] = '0;
        first = FAULT_NONE;
        for (int t = 0; t < nt; t++) begin
            base = t * NN;
            n = 0;
            steps = 0;
            tf = FAULT_NONE;
            stop = 0;
            while (!stop) begin
                if (split_of[base+n] < 0) begin
                    stop = 1;
                end else if (steps >= depth_cfg) begin
                    tf = FAULT_DEPTH;
                    stop = 1;
                end else begin
                    x = feat_of[split_of[base+n]];
                    n = (x <= thr_of[base+n]) ? left_of[base+n] : right_of[base+n];
                    steps++;
                end
            end
            if (tf == FAULT_NONE) begin
                total = 0;
                for (int c = 0; c < nc; c++) total += count_of[(base+n)*NC+c];
                if (total == 0) begin
                    tf = FAULT_EMPTY;
                end else begin
                    for (int c = 0; c < nc; c++) begin
                        p = (longint'(count_of[(base+n)*NC+c]) << 16) / total;
                        s = score[c] + p;
                        score[c] = (s > SCORE_MAX) ? SCORE_MAX : s[SCORE_W-1:0];
                    end
                end
            end
            if (first == FAULT_NONE) first = tf;
        end
        v.score = '0;
        v.win = '0;
        for (int c = 0; c < nc; c++) begin
            if (score[c] >= v.score) begin
                v.score = score[c];
                v.win = CLS_W'(c);
            end
        end
        v.lab = label_of[v.win];
        v.fault = first;
        return v;
    endfunction

    task automatic take_word(word_t w);
        int a;
        a = w.tree * NN + w.node;
        case (w.op)
            OP_WR_NODE: begin
                split_of[a] = w.fidx;
                thr_of[a] = w.num;
                left_of[a] = w.lc;
                right_of[a] = w.rc;
            end
            OP_WR_LEAF: count_of[a*NC+w.cls] = w.cnt;
            OP_WR_LABEL: label_of[w.cls] = w.lab;
            OP_WR_FEAT: if (w.fidx >= 0) feat_of[w.fidx] = w.num;
            OP_CLASSIFY: vote_queue.push_back(forest_vote());
            default: ;
        endcase
    endtask

    function automatic word_t any_word();
        word_t w;
        w.op = OP_CLASSIFY;
        w.tree = TREE_W'($urandom);
        w.node = NODE_W'($urandom);
        w.fidx = FIDX_W'($urandom);
        w.num = NUM_W'($urandom);
        w.lc = NODE_W'($urandom);
        w.rc = NODE_W'($urandom);
        w.cls = CLS_W'($urandom);
        w.cnt = CNT_W'($urandom);
        w.lab = LABEL_W'($urandom);
        return w;
    endfunction

    function automatic word_t node_word(int t, int n, int f, int th, int l, int r);
        word_t w;
        w = any_word();
        w.op = OP_WR_NODE;
        w.tree = TREE_W'(t);
        w.node = NODE_W'(n);
        w.fidx = FIDX_W'(f);
        w.num = NUM_W'(th);
        w.lc = NODE_W'(l);
        w.rc = NODE_W'(r);
        return w;
    endfunction

    function automatic word_t count_word(int t, int n, int c, int k);
        word_t w;
        w = any_word();
        w.op = OP_WR_LEAF;
        w.tree = TREE_W'(t);
        w.node = NODE_W'(n);
        w.cls = CLS_W'(c);
        w.cnt = CNT_W'(k);
        return w;
    endfunction

    function automatic logic [CNT_W-1:0] some_count();
        int r;
        r = $urandom_range(9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r < 4) return CNT_W'($urandom_range(15));
        return CNT_W'($urandom);
    endfunction

    // Only nodes 0 and 1 of each tree are ever reached: children stay in that range.
    function automatic word_t rand_word();
        word_t w;
        int r;
        w = any_word();
        r = $urandom_range(99);
        if (r < 25) begin
            w.op = OP_CLASSIFY;
        end else if (r < 50) begin
            w.op = OP_WR_NODE;
            if ($urandom_range(9) < 8) w.node = NODE_W'($urandom_range(1));
            w.fidx = $urandom_range(1) ? 7'($urandom_range(NF_USED-1))
                                       : 7'(7'h40 | $urandom_range(63));
            w.lc = NODE_W'($urandom_range(1));
            w.rc = NODE_W'($urandom_range(1));
        end else if (r < 75) begin
            w.op = OP_WR_LEAF;
            if ($urandom_range(9) < 8) w.node = NODE_W'($urandom_range(1));
            w.cnt = some_count();
        end else if (r < 88) begin
            w.op = OP_WR_FEAT;
        end else if (r < 95) begin
            w.op = OP_WR_LABEL;
        end else begin
            w.op = OP_W'($urandom_range(7, 5));
        end
        return w;
    endfunction

    task automatic drain();
        while (word_queue.size() != 0 || in_valid || vote_queue.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_TREES: trees_cfg = val[4:0];
            CFG_CLASSES: classes_cfg = val[3:0];
            CFG_DEPTH: depth_cfg = val;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    // driver: a word is held until taken
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_taken)) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                cur <= word_queue.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
            in_taken = 0;
        end
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECK FAILED");
            $finish;
        end
        if (in_valid && !o_in_stall) begin
            take_word(cur);
            in_taken = 1;
            words_sent++;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        vote_t e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            votes_seen++;
            if (o_fault != FAULT_NONE) faults_seen++;
            if (vote_queue.size() == 0) begin
                if (errors < 10) $display("unexpected result word at cycle %0d", cycles);
                errors++;
            end else begin
                e = vote_queue.pop_front();
                if (o_predicted_label !== e.lab || o_winning_class !== e.win ||
                    o_best_score !== e.score || o_fault !== e.fault) begin
                    if (errors < 10)
                        $display({"mismatch cycle %0d: label %0d/%0d class %0d/%0d ",
                                  "score %0d/%0d fault %0d/%0d (exp/got)"},
                                 cycles, e.lab, o_predicted_label, e.win, o_winning_class,
                                 e.score, o_best_score, e.fault, o_fault);
                    errors++;
                end
            end
        end
    end

    initial begin
        int setting [7][3];
        word_t w;
        setting = '{'{16, 8, 255}, '{1, 1, 1}, '{0, 8, 0}, '{31, 15, 3},
                    '{4, 2, 2}, '{16, 8, 6}, '{9, 5, 255}};
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // load a full forest: root split, node 1 as a leaf
        for (int c = 0; c < NC; c++) begin
            w = any_word();
            w.op = OP_WR_LABEL;
            w.cls = CLS_W'(c);
            if (c == 0) w.lab = 8'd0;
            if (c == NC-1) w.lab = 8'd255;
            word_queue.push_back(w);
        end
        for (int f = 0; f < NF_USED; f++) begin
            w = any_word();
            w.op = OP_WR_FEAT;
            w.fidx = FIDX_W'(f);
            word_queue.push_back(w);
        end
        for (int t = 0; t < NT; t++) begin
            word_queue.push_back(node_word(t, 0, $urandom_range(NF_USED-1),
                                           $urandom, 1, 1));
            word_queue.push_back(node_word(t, 1, (t % 2 == 0) ? -1 : -64, $urandom, 0, 0));
            for (int n = 0; n < 2; n++)
                for (int c = 0; c < NC; c++)
                    word_queue.push_back(count_word(t, n, c,
                        (t == 0 && n == 0) ? 0 : (t == NT-1) ? 65535 : some_count()));
        end

        // directed
        w = any_word(); word_queue.push_back(w);
        for (int k = 5; k < 8; k++) begin
            w = any_word();
            w.op = OP_W'(k);
            word_queue.push_back(w);
        end
        w = any_word(); w.op = OP_WR_FEAT; w.fidx = -1; word_queue.push_back(w);
        w = any_word(); w.op = OP_WR_FEAT; w.fidx = 63; w.num = -32768;
        word_queue.push_back(w);
        w = any_word(); w.op = OP_WR_FEAT; w.fidx = 0; w.num = 32767;
        word_queue.push_back(w);
        w = any_word(); word_queue.push_back(w);
        // root as a leaf with no samples
        word_queue.push_back(node_word(0, 0, -1, 0, 0, 0));
        w = any_word(); word_queue.push_back(w);
        // root looping on itself runs into the depth limit
        word_queue.push_back(node_word(0, 0, 0, 32767, 0, 0));
        w = any_word(); word_queue.push_back(w);
        word_queue.push_back(node_word(0, 0, 5, -32768, 1, 1));
        w = any_word(); word_queue.push_back(w);

        for (int ph = 0; ph < 7; ph++) begin
            if (ph == 3) begin
                send_idle_pct = 57;
                recv_stall_pct = 16;
            end else if (ph == 5) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            if (ph > 0) begin
                drain();
                write_reg(CFG_TREES, CFG_DATA_W'(setting[ph][0]));
                write_reg(CFG_CLASSES, CFG_DATA_W'(setting[ph][1]));
                write_reg(CFG_DEPTH, CFG_DATA_W'(setting[ph][2]));
            end
            for (int i = 0; i < 28; i++) word_queue.push_back(rand_word());
        end
        drain();

        $display("sent %0d words, checked %0d classifications (%0d with a fault), 7 settings",
                 words_sent, votes_seen, faults_seen);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
